### hw/rtl/bcs_pkg.sv
package bcs_pkg;

    localparam int BOID_CNT   = 1024;
    localparam int IDX_W      = 10;
    localparam int GAIN_BITS  = 16;
    localparam int SCALE_BITS = 24;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_SPEED  = 3'd2;
    localparam logic [2:0] CFG_EXTENT = 3'd3;
    localparam logic [2:0] CFG_IN_USE = 3'd4;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } boid_t;

    // request to the shared divide / square root unit
    typedef struct packed {
        logic        go;
        logic        sqrt_mode;
        logic [63:0] num;
        logic [31:0] den;
    } iu_req_t;

endpackage

### hw/rtl/boid_cohesion_step.sv
// Load: no result; the next word may follow at once.
// Compute: one store read per scanned boid, then up to three 64-step divides
// (centre x, y if neighbours; speed only over the limit) and a 32-step square
// root on the shared divide / root unit; busy stays high meanwhile.
// Results show for one cycle on done; the receiver cannot stall.
// Reset restores the default registers; the boid store is not cleared.
module boid_cohesion_step
    import bcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [IDX_W-1:0]    boid_index,
    input  logic signed [31:0]  in_pos_x,
    input  logic signed [31:0]  in_pos_y,
    input  logic signed [31:0]  in_vel_x,
    input  logic signed [31:0]  in_vel_y,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    output logic                done,
    output logic [IDX_W-1:0]    out_index,
    output logic signed [31:0]  out_pos_x,
    output logic signed [31:0]  out_pos_y,
    output logic signed [31:0]  out_vel_x,
    output logic signed [31:0]  out_vel_y,
    output logic [IDX_W-1:0]    neighbor_count
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SELF  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_PMUL  = 4'd5;
    localparam logic [3:0] ST_PADD  = 4'd6;
    localparam logic [3:0] ST_SQX   = 4'd7;
    localparam logic [3:0] ST_SQY   = 4'd8;
    localparam logic [3:0] ST_SQS   = 4'd9;
    localparam logic [3:0] ST_SQRT  = 4'd10;
    localparam logic [3:0] ST_DIVS  = 4'd11;
    localparam logic [3:0] ST_SCL   = 4'd12;
    localparam logic [3:0] ST_MOVE  = 4'd13;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -36'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] wrap32(input logic signed [31:0] p0,
                                                   input logic signed [31:0] v,
                                                   input logic [30:0] ext);
        logic signed [33:0] p;
        logic signed [33:0] w;
        p = 34'(p0) + 34'(v);
        w = $signed({3'b000, ext});
        if (p < 0)
        begin
            p = p + w;
        end
        if (p >= w)
        begin
            p = p - w;
        end
        return sat32(36'(p));
    endfunction

    // configuration
    logic [30:0] radius_reg;
    logic [15:0] gain_reg;
    logic [30:0] speed_reg;
    logic [30:0] extent_reg;
    logic [10:0] in_use_reg;

    // control
    logic [3:0]  state_reg;
    logic        done_reg;
    logic [10:0] j_reg;
    logic [1:0]  dcnt_reg;
    logic        comp_reg;
    logic        iss_v_reg;
    logic        a_v_reg;
    logic        b_v_reg;
    iu_req_t     iu_req_reg;

    // payload
    logic [IDX_W-1:0]   idx_reg;
    logic [10:0]        n_reg;
    logic [61:0]        r2_reg;
    boid_t              self_reg;
    logic [30:0]        dx_reg;
    logic [30:0]        dy_reg;
    logic signed [31:0] xa_reg;
    logic signed [31:0] ya_reg;
    logic [61:0]        dxsq_reg;
    logic [61:0]        dysq_reg;
    logic signed [31:0] xb_reg;
    logic signed [31:0] yb_reg;
    logic signed [41:0] sx_reg;
    logic signed [41:0] sy_reg;
    logic [IDX_W-1:0]   count_reg;
    logic signed [32:0] cx_reg;
    logic signed [32:0] cy_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic [63:0]        sqa_reg;
    logic [63:0]        sqb_reg;
    logic [24:0]        scale_reg;

    // store and shared unit
    logic               st_we;
    boid_t              st_wdata;
    logic [IDX_W-1:0]   st_raddr;
    boid_t              st_rdata;
    logic               iu_done;
    logic [63:0]        iu_quot;

    // scan datapath
    logic signed [32:0] ddx;
    logic signed [32:0] ddy;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic               near_ok;
    logic [62:0]        dsum;

    // other datapath
    logic               accept;
    logic [41:0]        sx_mag;
    logic [41:0]        sy_mag;
    logic signed [32:0] q_pos;
    logic signed [33:0] pull_diff;
    logic signed [34:0] pull;
    logic signed [31:0] v_cur;
    logic [31:0]        v_mag;
    logic [56:0]        v_scaled;
    logic signed [31:0] v_clamped;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign st_we    = accept && (req_type == REQ_LOAD);
    assign st_wdata = '{x: in_pos_x, y: in_pos_y, vx: in_vel_x, vy: in_vel_y};
    assign st_raddr = (state_reg == ST_IDLE) ? boid_index : j_reg[IDX_W-1:0];

    bcs_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (boid_index),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    bcs_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iu_req_reg),
        .done  (iu_done),
        .quot  (iu_quot)
    );

    always_comb
    begin
        ddx     = 33'(st_rdata.x) - 33'(self_reg.x);
        ddy     = 33'(st_rdata.y) - 33'(self_reg.y);
        adx     = ddx[32] ? 33'(-ddx) : 33'(ddx);
        ady     = ddy[32] ? 33'(-ddy) : 33'(ddy);
        near_ok = (adx[32:31] == 2'b00) && (ady[32:31] == 2'b00);
        dsum    = 63'(dxsq_reg) + 63'(dysq_reg);

        sx_mag  = sx_reg[41] ? 42'(-sx_reg) : 42'(sx_reg);
        sy_mag  = sy_reg[41] ? 42'(-sy_reg) : 42'(sy_reg);
        q_pos   = $signed({1'b0, iu_quot[31:0]});

        pull_diff = comp_reg ? (34'(cy_reg) - 34'(self_reg.y))
                             : (34'(cx_reg) - 34'(self_reg.x));
        pull      = 35'(prod_reg >>> GAIN_BITS);

        v_cur     = comp_reg ? vy_reg : vx_reg;
        v_mag     = v_cur[31] ? 32'(-v_cur) : 32'(v_cur);
        v_scaled  = 57'(v_mag) * 57'(scale_reg);
        v_clamped = v_cur[31] ? -$signed(v_scaled[55:24]) : $signed(v_scaled[55:24]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd3276800;
            gain_reg   <= 16'd66;
            speed_reg  <= 31'd131072;
            extent_reg <= 31'd65536000;
            in_use_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_GAIN:   gain_reg   <= cfg_data[15:0];
                CFG_SPEED:  speed_reg  <= cfg_data;
                CFG_EXTENT: extent_reg <= cfg_data;
                CFG_IN_USE: in_use_reg <= cfg_data[10:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            j_reg      <= '0;
            dcnt_reg   <= '0;
            comp_reg   <= 1'b0;
            iss_v_reg  <= 1'b0;
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            iu_req_reg <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            iu_req_reg.go <= 1'b0;
            iss_v_reg     <= 1'b0;
            a_v_reg       <= iss_v_reg && near_ok;
            b_v_reg       <= a_v_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req_type == REQ_COMPUTE))
                    begin
                        state_reg <= ST_SELF;
                    end
                end
                ST_SELF:
                begin
                    j_reg     <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (j_reg < n_reg)
                    begin
                        iss_v_reg <= (j_reg[IDX_W-1:0] != idx_reg) || j_reg[10];
                        j_reg     <= j_reg + 11'd1;
                    end
                    else
                    begin
                        dcnt_reg  <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    dcnt_reg <= dcnt_reg + 2'd1;
                    if (dcnt_reg == 2'd2)
                    begin
                        if (count_reg == '0)
                        begin
                            state_reg <= ST_SQX;
                        end
                        else
                        begin
                            iu_req_reg <= '{go: 1'b1, sqrt_mode: 1'b0,
                                            num: 64'(sx_mag), den: 32'(count_reg)};
                            comp_reg   <= 1'b0;
                            state_reg  <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (iu_done)
                    begin
                        if (!comp_reg)
                        begin
                            iu_req_reg <= '{go: 1'b1, sqrt_mode: 1'b0,
                                            num: 64'(sy_mag), den: 32'(count_reg)};
                            comp_reg   <= 1'b1;
                        end
                        else
                        begin
                            comp_reg  <= 1'b0;
                            state_reg <= ST_PMUL;
                        end
                    end
                end
                ST_PMUL:
                begin
                    state_reg <= ST_PADD;
                end
                ST_PADD:
                begin
                    comp_reg  <= !comp_reg;
                    state_reg <= comp_reg ? ST_SQX : ST_PMUL;
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    state_reg <= ST_SQS;
                end
                ST_SQS:
                begin
                    iu_req_reg <= '{go: 1'b1, sqrt_mode: 1'b1,
                                    num: sqa_reg + sqb_reg, den: 32'd0};
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (iu_done)
                    begin
                        if (iu_quot[31:0] > 32'(speed_reg))
                        begin
                            iu_req_reg <= '{go: 1'b1, sqrt_mode: 1'b0,
                                            num: {9'd0, speed_reg, 24'd0},
                                            den: iu_quot[31:0]};
                            state_reg  <= ST_DIVS;
                        end
                        else
                        begin
                            state_reg <= ST_MOVE;
                        end
                    end
                end
                ST_DIVS:
                begin
                    if (iu_done)
                    begin
                        comp_reg  <= 1'b0;
                        state_reg <= ST_SCL;
                    end
                end
                ST_SCL:
                begin
                    comp_reg  <= !comp_reg;
                    state_reg <= comp_reg ? ST_MOVE : ST_SCL;
                end
                ST_MOVE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        // scan pipeline: distance, squares, then compare and accumulate
        dx_reg   <= adx[30:0];
        dy_reg   <= ady[30:0];
        xa_reg   <= st_rdata.x;
        ya_reg   <= st_rdata.y;
        dxsq_reg <= 62'(dx_reg) * 62'(dx_reg);
        dysq_reg <= 62'(dy_reg) * 62'(dy_reg);
        xb_reg   <= xa_reg;
        yb_reg   <= ya_reg;
        if (b_v_reg && (dsum < 63'(r2_reg)))
        begin
            sx_reg    <= sx_reg + 42'(xb_reg);
            sy_reg    <= sy_reg + 42'(yb_reg);
            count_reg <= count_reg + 10'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_reg <= boid_index;
                n_reg   <= (in_use_reg > 11'(BOID_CNT)) ? 11'(BOID_CNT) : in_use_reg;
                r2_reg  <= 62'(radius_reg) * 62'(radius_reg);
            end
            ST_SELF:
            begin
                self_reg  <= st_rdata;
                vx_reg    <= st_rdata.vx;
                vy_reg    <= st_rdata.vy;
                sx_reg    <= '0;
                sy_reg    <= '0;
                count_reg <= '0;
            end
            ST_DIV:
            begin
                if (iu_done)
                begin
                    if (!comp_reg)
                    begin
                        cx_reg <= sx_reg[41] ? -q_pos : q_pos;
                    end
                    else
                    begin
                        cy_reg <= sy_reg[41] ? -q_pos : q_pos;
                    end
                end
            end
            ST_PMUL:
            begin
                prod_reg <= 51'(pull_diff) * 51'($signed({1'b0, gain_reg}));
            end
            ST_PADD:
            begin
                if (!comp_reg)
                begin
                    vx_reg <= sat32(36'(vx_reg) + 36'(pull));
                end
                else
                begin
                    vy_reg <= sat32(36'(vy_reg) + 36'(pull));
                end
            end
            ST_SQX:
            begin
                sqa_reg <= 64'(vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg))
                         * 64'(vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg));
            end
            ST_SQY:
            begin
                sqb_reg <= 64'(vy_reg[31] ? 32'(-vy_reg) : 32'(vy_reg))
                         * 64'(vy_reg[31] ? 32'(-vy_reg) : 32'(vy_reg));
            end
            ST_DIVS:
            begin
                if (iu_done)
                begin
                    scale_reg <= iu_quot[24:0];
                end
            end
            ST_SCL:
            begin
                if (!comp_reg)
                begin
                    vx_reg <= v_clamped;
                end
                else
                begin
                    vy_reg <= v_clamped;
                end
            end
            ST_MOVE:
            begin
                out_index      <= idx_reg;
                out_pos_x      <= wrap32(self_reg.x, vx_reg, extent_reg);
                out_pos_y      <= wrap32(self_reg.y, vy_reg, extent_reg);
                out_vel_x      <= vx_reg;
                out_vel_y      <= vy_reg;
                neighbor_count <= count_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_LOAD)) |=> !busy)
        else $error("load occupied the block");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_COMPUTE)) |=> busy)
        else $error("compute not taken");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_unit_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        iu_done |-> ((state_reg == ST_DIV) || (state_reg == ST_SQRT)
                     || (state_reg == ST_DIVS)))
        else $error("unit finished outside a wait state");

endmodule

### hw/rtl/bcs_store.sv
module bcs_store
    import bcs_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  boid_t            wdata,
    input  logic [IDX_W-1:0] raddr,
    output boid_t            rdata
);

    boid_t mem [BOID_CNT];
    boid_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bcs_iter.sv
module bcs_iter
    import bcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iu_req_t     req,
    output logic        done,
    output logic [63:0] quot
);

    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    logic        run_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [63:0] op_reg;
    logic [63:0] q_reg;
    logic [31:0] den_reg;
    logic [65:0] rem_reg;

    logic [65:0] shifted;
    logic [65:0] trial;
    logic [65:0] diff;
    logic        ge;

    // one restoring step: shift in one dividend bit or two radicand bits
    always_comb
    begin
        shifted = mode_reg ? {rem_reg[63:0], op_reg[63:62]} : {rem_reg[64:0], op_reg[63]};
        trial   = mode_reg ? {q_reg, 2'b01} : {34'd0, den_reg};
        ge      = (shifted >= trial);
        diff    = shifted - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.sqrt_mode ? SQRT_STEPS : DIV_STEPS;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            op_reg   <= req.num;
            den_reg  <= req.den;
            mode_reg <= req.sqrt_mode;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (run_reg)
        begin
            op_reg  <= mode_reg ? {op_reg[61:0], 2'b00} : {op_reg[62:0], 1'b0};
            rem_reg <= ge ? diff : shifted;
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
